// File: hw/rtl/i2c_mbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by the engine and its checker.
package i2c_mbe_pkg;

  localparam int unsigned PhaseWidth       = 16;
  localparam int unsigned BitCountWidth    = 4;
  localparam int unsigned ByteWidth        = 8;
  localparam logic [PhaseWidth-1:0] PhaseTicksReset = 16'd100;
  localparam logic [BitCountWidth-1:0] BitsPerByte  = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_SEND    = 3'd3,
    OP_RX_ACK  = 3'd4,
    OP_RX_NACK = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    START_READY     = 2'd0,
    START_BUS_BUSY  = 2'd1,
    START_BUS_ERROR = 2'd2
  } start_stat_e;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_S_SDA_HI  = 5'd1,
    ST_S_SCL_HI  = 5'd2,
    ST_S_SDA_LO  = 5'd3,
    ST_S_SCL_LO  = 5'd4,
    ST_P_SDA_LO  = 5'd5,
    ST_P_SCL_HI  = 5'd6,
    ST_P_SDA_HI  = 5'd7,
    ST_T_DATA    = 5'd8,
    ST_T_CLK_HI  = 5'd9,
    ST_T_CLK_LO  = 5'd10,
    ST_T_ACK_REL = 5'd11,
    ST_T_ACK_CLK = 5'd12,
    ST_R_CLK_HI  = 5'd13,
    ST_R_CLK_LO  = 5'd14,
    ST_A_DRIVE   = 5'd15,
    ST_A_CLK_HI  = 5'd16,
    ST_A_CLK_LO  = 5'd17
  } step_e;

endpackage

// File: hw/rtl/i2c_mbe_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the I2C master byte engine:
// the tick request channel and the result channel. No dependencies.
interface i2c_mbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, operation, tx_byte, sda_in, input ready);
  modport sink   (input valid, operation, tx_byte, sda_in, output ready);
endinterface

interface i2c_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic [1:0] start_status;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
                  start_status, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
                  start_status, output ready);
endinterface

// File: hw/rtl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// I2C master byte engine: bus sequencer advanced one tick per request.
// Depends on i2c_mbe_pkg and the channel interfaces in i2c_mbe_if.sv.
//
// Usage: every request on in_i is one tick of the bus sequencer. It carries
// the sampled SDA level and, while the engine is idle, an optional command
// (start, stop, send byte, receive with ack or nack). Each request yields
// exactly one result on out_o with the SCL/SDA drive levels, busy, a done
// pulse, the last received byte, the ack flag and the last start status.
// Commands arriving while busy, or on the completing tick, are ignored.
// cfg_we_i/cfg_wdata_i write the phase length in ticks (0 behaves as 1);
// write it only while the engine is idle.
// The result is registered and offered in the cycle after its request is
// accepted. The sequencer state and the result register update together on
// each accepted request, one request every cycle unless the receiver stalls;
// a held result blocks in_i.ready until taken; no tick is lost or duplicated.
// Reset releases both lines, returns to idle, clears the received byte,
// ack flag and start status, and loads the phase length PhaseTicksRst (100 ticks by default).
module i2c_master_byte_engine
  import i2c_mbe_pkg::*;
#(
  parameter logic [PhaseWidth-1:0] PhaseTicksRst = PhaseTicksReset
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [PhaseWidth-1:0] cfg_wdata_i,
  i2c_mbe_in_if.sink            in_i,
  i2c_mbe_out_if.source         out_o
);

  logic [PhaseWidth-1:0]    phase_ticks_q;
  step_e                    step_q, step_d;
  logic [PhaseWidth-1:0]    phase_cnt_q, phase_cnt_d;
  logic [BitCountWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [ByteWidth-1:0]     shifter_q, shifter_d;
  logic                     scl_q, scl_d;
  logic                     sda_q, sda_d;
  logic [ByteWidth-1:0]     received_q, received_d;
  logic                     ack_q, ack_d;
  start_stat_e              start_q, start_d;
  logic                     nack_mode_q, nack_mode_d;

  logic                     accept;
  logic                     enter;
  logic                     done;
  logic                     phase_end;
  logic [PhaseWidth-1:0]    limit;
  logic [PhaseWidth-1:0]    cnt_inc;
  logic [BitCountWidth-1:0] bit_inc;

  logic                     out_valid_q;
  logic                     res_scl_q, res_sda_q, res_busy_q, res_done_q, res_ack_q;
  logic [ByteWidth-1:0]     res_rx_q;
  logic [1:0]               res_start_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign limit     = (phase_ticks_q == '0) ? {{(PhaseWidth-1){1'b0}}, 1'b1} : phase_ticks_q;
  assign cnt_inc   = phase_cnt_q + {{(PhaseWidth-1){1'b0}}, 1'b1};
  assign bit_inc   = bit_cnt_q + {{(BitCountWidth-1){1'b0}}, 1'b1};
  assign phase_end = (step_q != ST_IDLE) && (cnt_inc >= limit);

  // Next step of the sequencer.
  always_comb begin
    step_d      = step_q;
    phase_cnt_d = (step_q == ST_IDLE) ? phase_cnt_q : cnt_inc;
    bit_cnt_d   = bit_cnt_q;
    enter       = 1'b0;
    done        = 1'b0;
    if (step_q == ST_IDLE) begin
      unique case (in_i.operation)
        OP_START: begin
          step_d = ST_S_SDA_HI;
          enter  = 1'b1;
        end
        OP_STOP: begin
          step_d = ST_P_SDA_LO;
          enter  = 1'b1;
        end
        OP_SEND: begin
          step_d    = ST_T_DATA;
          bit_cnt_d = '0;
          enter     = 1'b1;
        end
        OP_RX_ACK, OP_RX_NACK: begin
          step_d    = ST_R_CLK_HI;
          bit_cnt_d = '0;
          enter     = 1'b1;
        end
        default: ;
      endcase
    end else if (phase_end) begin
      enter = 1'b1;
      unique case (step_q)
        ST_S_SDA_HI: step_d = ST_S_SCL_HI;
        ST_S_SCL_HI: begin
          // A low SDA with both lines released means another master holds the bus.
          if (!in_i.sda_in) begin
            step_d = ST_IDLE;
            done   = 1'b1;
          end else begin
            step_d = ST_S_SDA_LO;
          end
        end
        ST_S_SDA_LO: step_d = ST_S_SCL_LO;
        ST_P_SDA_LO: step_d = ST_P_SCL_HI;
        ST_P_SCL_HI: step_d = ST_P_SDA_HI;
        ST_T_DATA:   step_d = ST_T_CLK_HI;
        ST_T_CLK_HI: step_d = ST_T_CLK_LO;
        ST_T_CLK_LO: begin
          bit_cnt_d = bit_inc;
          step_d    = (bit_inc < BitsPerByte) ? ST_T_DATA : ST_T_ACK_REL;
        end
        ST_T_ACK_REL: step_d = ST_T_ACK_CLK;
        ST_R_CLK_HI:  step_d = ST_R_CLK_LO;
        ST_R_CLK_LO: begin
          bit_cnt_d = bit_inc;
          step_d    = (bit_inc < BitsPerByte) ? ST_R_CLK_HI : ST_A_DRIVE;
        end
        ST_A_DRIVE:  step_d = ST_A_CLK_HI;
        ST_A_CLK_HI: step_d = ST_A_CLK_LO;
        default: begin
          step_d = ST_IDLE;
          done   = 1'b1;
        end
      endcase
    end
    if (enter) begin
      phase_cnt_d = '0;
    end
  end

  // Pin levels and data path for the step being entered.
  always_comb begin
    shifter_d   = shifter_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    received_d  = received_q;
    ack_d       = ack_q;
    start_d     = start_q;
    nack_mode_d = nack_mode_q;

    if (step_q == ST_IDLE) begin
      if (in_i.operation == OP_SEND) begin
        shifter_d = in_i.tx_byte;
      end else if (in_i.operation == OP_RX_ACK || in_i.operation == OP_RX_NACK) begin
        shifter_d   = '0;
        nack_mode_d = (in_i.operation == OP_RX_NACK);
      end
    end else if (phase_end) begin
      unique case (step_q)
        ST_S_SCL_HI: begin
          if (!in_i.sda_in) begin
            start_d = START_BUS_BUSY;
          end
        end
        ST_S_SCL_LO: start_d = in_i.sda_in ? START_BUS_ERROR : START_READY;
        ST_T_ACK_CLK: begin
          ack_d = !in_i.sda_in;
          scl_d = 1'b0;
        end
        ST_R_CLK_HI: shifter_d = {shifter_q[ByteWidth-2:0], in_i.sda_in};
        ST_R_CLK_LO: begin
          if (!(bit_inc < BitsPerByte)) begin
            received_d = shifter_q;
          end
        end
        default: ;
      endcase
    end

    if (enter) begin
      unique case (step_d)
        ST_S_SDA_HI, ST_P_SDA_HI, ST_T_ACK_REL: sda_d = 1'b1;
        ST_S_SDA_LO, ST_P_SDA_LO:               sda_d = 1'b0;
        ST_S_SCL_HI, ST_P_SCL_HI, ST_T_CLK_HI,
        ST_T_ACK_CLK, ST_A_CLK_HI:              scl_d = 1'b1;
        ST_S_SCL_LO, ST_T_CLK_LO, ST_R_CLK_LO,
        ST_A_CLK_LO:                            scl_d = 1'b0;
        ST_T_DATA: begin
          // The byte was loaded into the shifter this tick when the command starts.
          scl_d     = 1'b0;
          sda_d     = shifter_d[ByteWidth-1];
          shifter_d = {shifter_d[ByteWidth-2:0], 1'b0};
        end
        ST_R_CLK_HI: begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        ST_A_DRIVE: sda_d = nack_mode_d;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksRst;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      phase_cnt_q <= '0;
      bit_cnt_q   <= '0;
      shifter_q   <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      received_q  <= '0;
      ack_q       <= 1'b0;
      start_q     <= START_READY;
      nack_mode_q <= 1'b0;
    end else if (accept) begin
      step_q      <= step_d;
      phase_cnt_q <= phase_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      shifter_q   <= shifter_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      received_q  <= received_d;
      ack_q       <= ack_d;
      start_q     <= start_d;
      nack_mode_q <= nack_mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_scl_q   <= scl_d;
      res_sda_q   <= sda_d;
      res_busy_q  <= (step_d != ST_IDLE);
      res_done_q  <= done;
      res_rx_q    <= received_d;
      res_ack_q   <= ack_d;
      res_start_q <= start_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.scl_out      = res_scl_q;
  assign out_o.sda_out      = res_sda_q;
  assign out_o.busy_res     = res_busy_q;
  assign out_o.done_res     = res_done_q;
  assign out_o.rx_byte      = res_rx_q;
  assign out_o.ack_seen     = res_ack_q;
  assign out_o.start_status = res_start_q;

endmodule

// File: hw/rtl/i2c_mbe_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the I2C master byte engine, bound to the engine module.
// Depends on i2c_mbe_pkg and i2c_master_byte_engine.
module i2c_mbe_checker
  import i2c_mbe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       busy_i,
  input logic       done_i,
  input logic [1:0] start_status_i
);

  // A stalled result must stay offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // Every accepted request produces a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted request gave no result");

  // A completing command leaves the engine idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_i |-> !busy_i)
    else $error("done reported while still busy");

  // Start status never takes the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (start_status_i == START_READY || start_status_i == START_BUS_BUSY ||
                     start_status_i == START_BUS_ERROR))
    else $error("invalid start status");

endmodule

bind i2c_master_byte_engine i2c_mbe_checker u_i2c_mbe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .busy_i         (out_o.busy_res),
  .done_i         (out_o.done_res),
  .start_status_i (out_o.start_status)
);
